[design/brsc_pkg.sv]
// shared types, constants and coding functions of the byte pair router
`default_nettype none

package brsc_pkg;

  localparam logic MODE_HOST = 1'b0;
  localparam logic MODE_NET  = 1'b1;

  localparam logic DEST_HOST = 1'b0;
  localparam logic DEST_NET  = 1'b1;

  localparam int unsigned HOST_ADDR_TAG = 32;
  localparam logic [7:0] HOST_ADDR_BASE = 8'(HOST_ADDR_TAG * 4);

  localparam int unsigned MAX_SHIFTS = 7;

  typedef struct packed {
    logic       is_err;
    logic [7:0] hi;
    logic [7:0] lo;
  } brsc_cmd_t;

  function automatic logic [6:0] rev7(input logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) begin
      r[6-i] = v[i];
    end
    return r;
  endfunction

  function automatic logic [6:0] enc_step(input logic [6:0] t);
    return {t[6] ^ t[0], t[6:1]};
  endfunction

  function automatic logic [6:0] dec_step(input logic [6:0] t);
    return {t[5:0], t[6] ^ t[5]};
  endfunction

  function automatic brsc_cmd_t encode_pair(input logic [1:0] addr, input logic [6:0] data);
    logic [6:0] t;
    logic [2:0] n;
    logic       e;
    brsc_cmd_t  c;
    t = data;
    n = data[4:2];
    e = ^data;
    for (int i = 0; i < MAX_SHIFTS; i++) begin
      if (3'(i) < n) begin
        t = enc_step(t);
      end
    end
    if (e) begin
      t = rev7(t);
    end
    c.is_err = 1'b0;
    c.hi     = {2'b11, addr, t[3:0]};
    c.lo     = {1'b0, e, n, t[6:4]};
    return c;
  endfunction

  function automatic logic [6:0] decode_data(input logic [7:0] hi, input logic [7:0] lo);
    logic [6:0] t;
    logic [2:0] n;
    t = {lo[2:0], hi[3:0]};
    n = lo[5:3];
    if (lo[6]) begin
      t = rev7(t);
    end
    for (int i = 0; i < MAX_SHIFTS; i++) begin
      if (3'(i) < n) begin
        t = dec_step(t);
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

[design/byte_pair_router_with_scrambler_core.sv]
// top level of the byte pair router with scrambler
// an accepted completed pair or misordered byte is written into the command queue and then
//   loaded into the output register, which raises out_valid
// throughput: one input byte per cycle while the command queue has room; results
//   leave at one per cycle from the output register while out_ready is high, a pair giving two bytes
// reset: synchronous, clears pair flags, queue, output valid and node_address to 0
`default_nettype none

module byte_pair_router_with_scrambler_core
  import brsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       mode,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            destination,
  output logic [7:0]      out_byte,
  output logic            last,
  output logic            order_error
);

  logic       cfg_write;
  logic [1:0] node_address;
  logic       push_valid;
  logic       push_ready;
  brsc_cmd_t  push_cmd;
  logic       q_valid;
  logic       q_ready;
  brsc_cmd_t  q_cmd;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address <= '0;
    end else if (cfg_write) begin
      node_address <= cfg_data;
    end
  end

  brsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  brsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  brsc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .node_address (node_address),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_cmd        (q_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .destination  (destination),
    .out_byte     (out_byte),
    .last         (last),
    .order_error  (order_error)
  );

endmodule

`default_nettype wire

[design/brsc_front.sv]
// front end: pair assembly per port, host pair encoding, error detection
`default_nettype none

module brsc_front
  import brsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      mode,
  input  wire logic [7:0] in_byte,
  output logic           push_valid,
  input  wire logic      push_ready,
  output brsc_cmd_t      push_cmd
);

  logic       host_expect_data, host_expect_data_next;
  logic [1:0] host_held_address, host_held_address_next;
  logic       net_expect_low, net_expect_low_next;
  logic [7:0] net_held_high, net_held_high_next;
  logic       accept;
  logic       top_bit;
  brsc_cmd_t  err_cmd;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;
  assign top_bit  = in_byte[7];

  always_comb begin
    err_cmd        = '0;
    err_cmd.is_err = 1'b1;
  end

  always_comb begin
    host_expect_data_next  = host_expect_data;
    host_held_address_next = host_held_address;
    net_expect_low_next    = net_expect_low;
    net_held_high_next     = net_held_high;
    push_valid             = 1'b0;
    push_cmd               = err_cmd;
    if (accept) begin
      if (mode == MODE_HOST) begin
        if (!host_expect_data) begin
          if (!top_bit) begin
            push_valid = 1'b1;
          end else begin
            host_held_address_next = in_byte[1:0];
            host_expect_data_next  = 1'b1;
          end
        end else if (top_bit) begin
          push_valid = 1'b1;
        end else begin
          push_valid            = 1'b1;
          push_cmd              = encode_pair(host_held_address, in_byte[6:0]);
          host_expect_data_next = 1'b0;
        end
      end else begin
        if (!net_expect_low) begin
          if (!top_bit) begin
            push_valid = 1'b1;
          end else begin
            net_held_high_next  = in_byte;
            net_expect_low_next = 1'b1;
          end
        end else if (top_bit) begin
          push_valid = 1'b1;
        end else begin
          push_valid          = 1'b1;
          push_cmd.is_err     = 1'b0;
          push_cmd.hi         = net_held_high;
          push_cmd.lo         = in_byte;
          net_expect_low_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      host_expect_data <= 1'b0;
      net_expect_low   <= 1'b0;
    end else begin
      host_expect_data <= host_expect_data_next;
      net_expect_low   <= net_expect_low_next;
    end
    host_held_address <= host_held_address_next;
    net_held_high     <= net_held_high_next;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> push_ready)
    else $error("front pushed into a full queue");

  a_pair_clears_host: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_HOST && host_expect_data && !top_bit) |=> !host_expect_data)
    else $error("host pair state not cleared after data byte");

  a_net_first_no_push: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == MODE_NET && !net_expect_low && top_bit) |-> !push_valid)
    else $error("network high byte produced a transaction");

endmodule

`default_nettype wire

[design/brsc_queue.sv]
// short command queue between front end and back end
`default_nettype none

module brsc_queue
  import brsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire brsc_cmd_t push_cmd,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output brsc_cmd_t      pop_cmd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  brsc_cmd_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not follow push");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("empty queue with pointers apart");

endmodule

`default_nettype wire

[design/brsc_back.sv]
// back end: routing, decoding and the output register
`default_nettype none

module brsc_back
  import brsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic [1:0] node_address,
  input  wire logic      q_valid,
  output logic           q_ready,
  input  wire brsc_cmd_t q_cmd,
  output logic           out_valid,
  input  wire logic      out_ready,
  output logic           destination,
  output logic [7:0]     out_byte,
  output logic           last,
  output logic           order_error
);

  logic       pend_valid, pend_valid_next;
  logic       pend_dest, pend_dest_next;
  logic [7:0] pend_byte, pend_byte_next;
  logic       out_valid_next;
  logic       destination_next;
  logic [7:0] out_byte_next;
  logic       last_next;
  logic       order_error_next;
  logic       load;
  logic       match;
  logic [1:0] pair_addr;

  assign load      = !out_valid || out_ready;
  assign q_ready   = load && !pend_valid;
  assign pair_addr = q_cmd.hi[5:4];
  assign match     = (pair_addr == node_address);

  always_comb begin
    out_valid_next   = out_valid;
    destination_next = destination;
    out_byte_next    = out_byte;
    last_next        = last;
    order_error_next = order_error;
    pend_valid_next  = pend_valid;
    pend_dest_next   = pend_dest;
    pend_byte_next   = pend_byte;
    if (load) begin
      if (pend_valid) begin
        out_valid_next   = 1'b1;
        destination_next = pend_dest;
        out_byte_next    = pend_byte;
        last_next        = 1'b1;
        order_error_next = 1'b0;
        pend_valid_next  = 1'b0;
      end else if (q_valid) begin
        out_valid_next = 1'b1;
        if (q_cmd.is_err) begin
          destination_next = DEST_HOST;
          out_byte_next    = '0;
          last_next        = 1'b1;
          order_error_next = 1'b1;
        end else begin
          last_next        = 1'b0;
          order_error_next = 1'b0;
          pend_valid_next  = 1'b1;
          if (match) begin
            destination_next = DEST_HOST;
            out_byte_next    = HOST_ADDR_BASE | {6'b0, pair_addr};
            pend_dest_next   = DEST_HOST;
            pend_byte_next   = {1'b0, decode_data(q_cmd.hi, q_cmd.lo)};
          end else begin
            destination_next = DEST_NET;
            out_byte_next    = q_cmd.hi;
            pend_dest_next   = DEST_NET;
            pend_byte_next   = q_cmd.lo;
          end
        end
      end else begin
        out_valid_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      pend_valid <= pend_valid_next;
    end
    destination <= destination_next;
    out_byte    <= out_byte_next;
    last        <= last_next;
    order_error <= order_error_next;
    pend_dest   <= pend_dest_next;
    pend_byte   <= pend_byte_next;
  end

  a_pend_behind_first: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (out_valid && !last && !order_error))
    else $error("second result pending without its first shown");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && order_error) |-> (last && out_byte == 8'h00 && destination == DEST_HOST))
    else $error("malformed error transaction");

  a_same_dest: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (pend_dest == destination))
    else $error("pair results routed to different ports");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench of the byte pair router: directed pairs, misordered bytes, random traffic
module tb_top
  import brsc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       dest;
    logic [7:0] data;
    logic       last;
    logic       err;
  } route_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic       mode;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       out_ready;
  logic       destination;
  logic [7:0] out_byte;
  logic       last;
  logic       order_error;

  route_result_t expected_routes[$];

  logic [1:0] node_addr_q;
  logic       host_want_data;
  logic [1:0] host_addr_held;
  logic       net_want_low;
  logic [7:0] net_high_held;

  bit in_gaps_on;
  bit out_stall_on;
  int fail_count;

  byte_pair_router_with_scrambler_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .destination (destination),
    .out_byte    (out_byte),
    .last        (last),
    .order_error (order_error)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [6:0] reverse7(input logic [6:0] v);
    logic [6:0] r;
    for (int i = 0; i < 7; i++) begin
      r[6-i] = v[i];
    end
    return r;
  endfunction

  // returns {high, low}
  function automatic logic [15:0] scramble_pair(input logic [1:0] a, input logic [6:0] d);
    logic [6:0] t;
    logic [2:0] cnt;
    logic       par;
    t   = d;
    cnt = d[4:2];
    par = ^d;
    for (int i = 0; i < int'(cnt); i++) begin
      t = {t[6] ^ t[0], t[6:1]};
    end
    if (par) begin
      t = reverse7(t);
    end
    return {2'b11, a, t[3:0], 1'b0, par, cnt, t[6:4]};
  endfunction

  function automatic logic [6:0] unscramble(input logic [7:0] hi, input logic [7:0] lo);
    logic [6:0] t;
    logic [2:0] cnt;
    t   = {lo[2:0], hi[3:0]};
    cnt = lo[5:3];
    if (lo[6]) begin
      t = reverse7(t);
    end
    for (int i = 0; i < int'(cnt); i++) begin
      t = {t[5:0], t[6] ^ t[5]};
    end
    return t;
  endfunction

  function automatic void expect_pair_routes(input logic [7:0] hi, input logic [7:0] lo);
    logic [1:0] a;
    a = hi[5:4];
    if (a == node_addr_q) begin
      expected_routes.push_back(route_result_t'{DEST_HOST, HOST_ADDR_BASE | {6'b0, a}, 1'b0, 1'b0});
      expected_routes.push_back(route_result_t'{DEST_HOST, {1'b0, unscramble(hi, lo)}, 1'b1, 1'b0});
    end else begin
      expected_routes.push_back(route_result_t'{DEST_NET, hi, 1'b0, 1'b0});
      expected_routes.push_back(route_result_t'{DEST_NET, lo, 1'b1, 1'b0});
    end
  endfunction

  function automatic void predict_node_byte(input logic m, input logic [7:0] b);
    logic [15:0] pair;
    logic        misordered;
    misordered = 1'b0;
    if (m == MODE_HOST) begin
      if (!host_want_data) begin
        if (!b[7]) begin
          misordered = 1'b1;
        end else begin
          host_addr_held = b[1:0];
          host_want_data = 1'b1;
        end
      end else if (b[7]) begin
        misordered = 1'b1;
      end else begin
        pair = scramble_pair(host_addr_held, b[6:0]);
        host_want_data = 1'b0;
        expect_pair_routes(pair[15:8], pair[7:0]);
      end
    end else begin
      if (!net_want_low) begin
        if (!b[7]) begin
          misordered = 1'b1;
        end else begin
          net_high_held = b;
          net_want_low  = 1'b1;
        end
      end else if (b[7]) begin
        misordered = 1'b1;
      end else begin
        net_want_low = 1'b0;
        expect_pair_routes(net_high_held, b);
      end
    end
    if (misordered) begin
      expected_routes.push_back(route_result_t'{DEST_HOST, 8'h00, 1'b1, 1'b1});
    end
  endfunction

  task automatic send_byte(input logic m, input logic [7:0] b);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    predict_node_byte(m, b);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (expected_routes.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic write_node_address(input logic [1:0] v);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    cfg_valid   <= 1'b0;
    node_addr_q = v;
  endtask

  // address and data extremes, both parities, zero and full shift counts
  task automatic test_host_pairs();
    send_byte(MODE_HOST, 8'h80);
    send_byte(MODE_HOST, 8'h00);
    send_byte(MODE_HOST, 8'h83);
    send_byte(MODE_HOST, 8'h7F);
    send_byte(MODE_HOST, 8'hFD);
    send_byte(MODE_HOST, 8'h1C);
    send_byte(MODE_HOST, 8'hC2);
    send_byte(MODE_HOST, 8'h5A);
  endtask

  task automatic test_misordered_bytes();
    send_byte(MODE_HOST, 8'h00);
    send_byte(MODE_HOST, 8'h81);
    send_byte(MODE_HOST, 8'hFF);
    send_byte(MODE_HOST, 8'h00);
    send_byte(MODE_NET, 8'h7F);
    send_byte(MODE_NET, 8'hC0);
    send_byte(MODE_NET, 8'h80);
    send_byte(MODE_NET, 8'h3F);
  endtask

  // address bits 5:4 of the high byte at 0 and 3, matching and forwarded
  task automatic test_net_pairs();
    send_byte(MODE_NET, 8'h80);
    send_byte(MODE_NET, 8'h00);
    send_byte(MODE_NET, 8'hBF);
    send_byte(MODE_NET, 8'h7F);
  endtask

  task automatic test_port_interleave();
    send_byte(MODE_HOST, 8'h82);
    send_byte(MODE_NET, 8'hA5);
    send_byte(MODE_HOST, 8'h33);
    send_byte(MODE_NET, 8'h12);
  endtask

  // mostly well-formed pairs on both ports with random content, the rest noise
  task automatic test_random_traffic();
    logic       m;
    logic [7:0] b;
    logic [1:0] addr_seq[4];
    addr_seq = '{2'd0, 2'd3, 2'd1, 2'd2};
    for (int phase = 0; phase < 12; phase++) begin
      write_node_address(phase < 4 ? addr_seq[phase] : 2'($urandom_range(0, 3)));
      in_gaps_on   = phase[0];
      out_stall_on = phase[1];
      for (int k = 0; k < 125; k++) begin
        m = 1'($urandom_range(0, 1));
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8) begin
          b[7] = (m == MODE_HOST) ? !host_want_data : !net_want_low;
        end
        send_byte(m, b);
      end
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data  <= 2'd0;
    in_valid  <= 1'b0;
    mode      <= MODE_HOST;
    in_byte   <= 8'h00;
    node_addr_q    = 2'd0;
    host_want_data = 1'b0;
    host_addr_held = 2'd0;
    net_want_low   = 1'b0;
    net_high_held  = 8'h00;
    in_gaps_on     = 1'b0;
    out_stall_on   = 1'b0;
    fail_count     = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_host_pairs();
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    test_misordered_bytes();
    test_net_pairs();
    test_port_interleave();
    test_random_traffic();

    settle_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) begin
      @(posedge clk);
    end
    forever begin
      stall = out_stall_on ? $urandom_range(0, 7) : 0;
      repeat (stall) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) begin
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    route_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_routes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected transaction: dest=%0d byte=%02h last=%0d err=%0d",
                   destination, out_byte, last, order_error);
        end
      end else begin
        want = expected_routes.pop_front();
        if (destination !== want.dest || out_byte !== want.data ||
            last !== want.last || order_error !== want.err) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected dest=%0d byte=%02h last=%0d err=%0d,",
                     want.dest, want.data, want.last, want.err,
                     " got dest=%0d byte=%02h last=%0d err=%0d",
                     destination, out_byte, last, order_error);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
design/brsc_pkg.sv
design/brsc_front.sv
design/brsc_queue.sv
design/brsc_back.sv
design/byte_pair_router_with_scrambler_core.sv
tb/sv/tb_top.sv
